// ===== sv/tcrcw_pkg.sv =====
// Shared types and constants for the TCP Reno congestion window unit.
// Depends on nothing; imported by the controller, the datapath and the top level.
package tcrcw_pkg;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned MssW    = 16;
  localparam int unsigned WinW    = 32;
  localparam int unsigned FlightW = 31;
  localparam int unsigned DupW    = 16;
  localparam int unsigned DivW    = 31;
  localparam int unsigned DivCntW = $clog2(DivW);
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;

  // Request codes carried on in_tuser.
  localparam logic [ReqW-1:0] REQ_NEW_ACK   = 3'd0;
  localparam logic [ReqW-1:0] REQ_OTHER_ACK = 3'd1;
  localparam logic [ReqW-1:0] REQ_DUPACK    = 3'd2;
  localparam logic [ReqW-1:0] REQ_ECN       = 3'd3;
  localparam logic [ReqW-1:0] REQ_TIMEOUT   = 3'd4;
  localparam logic [ReqW-1:0] REQ_EXIT      = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_MSS   = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam logic [MssW-1:0] MSS_RESET   = 16'd1460;
  localparam logic [WinW-1:0] LIMIT_RESET = 32'd1073741824;
  localparam logic [WinW-1:0] WIN_RESET   = 32'd4380;
  localparam logic [WinW-1:0] SAT32       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_a;
    logic mul_b;
    logic commit;
  } tcrcw_cmd_t;

  typedef struct packed {
    logic div_last;
  } tcrcw_status_t;

endpackage

// ===== sv/tcp_reno_congestion_window_unit.sv =====
// Top level of the TCP Reno congestion window unit.
// Depends on tcrcw_pkg, tcrcw_ctrl and tcrcw_dp.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  in      | in  | in_tvalid / in_tready  | in_tuser = req_type, in_tdata = rest
//  out     | out | out_tvalid / out_tready| out_tdata = window, threshold, flags
//  cfg     | in  | cfg_wr_en              | cfg_index, cfg_wdata
//
// A request is accepted in the idle state, then runs through the restoring divide
// by MSS (one quotient bit a cycle), two multiplies for threshold and window, and
// one commit. A new request is taken only once the unit is back in the idle state.
// Reset (rst_n low, synchronous) restores MSS 1460, limit 2^30, window 4380,
// threshold all ones, counter and recovery flags clear.
// A new request is taken while the previous result waits in the output register;
// commit holds until that register is free, so a stalled out side stalls the unit.
module tcp_reno_congestion_window_unit
  import tcrcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Request channel.
  input  logic                in_tvalid,
  output logic                in_tready,
  // [30:0] flight_bytes, [46:31] dupack_count, [47] window_reduced,
  // [48] is_retransmit, [49] backoff_active, [55:50] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [2:0] req_type
  input  logic [ReqW-1:0]     in_tuser,
  // Result channel.
  output logic                out_tvalid,
  input  logic                out_tready,
  // [31:0] congestion_window, [63:32] slow_start_threshold, [64] fast_recovery,
  // [65] congestion_recovery, [71:66] zero
  output logic [OutDataW-1:0] out_tdata,
  // Configuration writes: index 0 max_segment_size, index 1 window_limit.
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [WinW-1:0]     cfg_wdata
);

  tcrcw_cmd_t    cmd;
  tcrcw_status_t status;

  // Sequence each request through divide, multiply and commit.
  tcrcw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Hold the window state and do the arithmetic.
  tcrcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_tuser),
    .in_data   (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_tdata)
  );

endmodule

// ===== sv/tcrcw_ctrl.sv =====
// Sequencer for the congestion window unit: capture, divide, two multiplies, commit.
// Depends on tcrcw_pkg; drives the command struct of tcrcw_dp.
module tcrcw_ctrl
  import tcrcw_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tcrcw_status_t status,
  output tcrcw_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_A,
    ST_MUL_B,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = in_tvalid && (state_r == ST_IDLE);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_a    = (state_r == ST_MUL_A);
    cmd.mul_b    = (state_r == ST_MUL_B);
    cmd.commit   = (state_r == ST_COMMIT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (status.div_last) state_r <= ST_MUL_A;
        end
        ST_MUL_A:  state_r <= ST_MUL_B;
        ST_MUL_B:  state_r <= ST_COMMIT;
        ST_COMMIT: begin
          if (slot_free) state_r <= ST_IDLE;
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("commit while result register still occupied");
  a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.div_step)
    else $error("accepted request did not start the divide");
  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && status.div_last) |=> cmd.mul_a)
    else $error("divide end did not advance to multiply");
  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("commit did not present a result");
`endif

endmodule

// ===== sv/tcrcw_dp.sv =====
// Datapath: config registers, window state, serial divider by MSS, 32x16 multiplier.
// Depends on tcrcw_pkg; sequenced by tcrcw_ctrl through the command struct.
module tcrcw_dp
  import tcrcw_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [WinW-1:0]     cfg_wdata,
  input  logic [ReqW-1:0]     in_req,
  input  logic [InDataW-1:0]  in_data,
  input  tcrcw_cmd_t          cmd,
  output tcrcw_status_t       status,
  output logic [OutDataW-1:0] out_data
);

  // Configuration.
  logic [MssW-1:0] mss_r;
  logic [WinW-1:0] limit_r;

  // Connection state.
  logic [WinW-1:0] win_r, win_nxt;
  logic [WinW-1:0] thr_r, thr_nxt;
  logic [WinW-1:0] ctr_r, ctr_nxt;
  logic            fr_r, fr_nxt;
  logic            cr_r, cr_nxt;

  // Captured request.
  logic [ReqW-1:0] req_r;
  logic [DupW-1:0] dup_r;
  logic            reduced_r;
  logic            rexmit_r;

  // Divider.
  logic [DivW-1:0]    quo_r;
  logic [MssW-1:0]    rem_r;
  logic [DivCntW-1:0] cnt_r;
  logic [MssW:0]      trial;
  logic               ge;
  logic [DivW-1:0]    npkt;
  logic [DivW-1:0]    dividend;

  // Multiplier results, saturated.
  logic [WinW-1:0]      thr_calc_r;
  logic [WinW-1:0]      win_calc_r;
  logic [WinW-1:0]      mul_a_op;
  logic [WinW-1:0]      mul_b_op;
  logic [WinW-1:0]      mul_op;
  logic [WinW+MssW-1:0] prod;
  logic [WinW-1:0]      prod_sat;

  // Commit arithmetic.
  logic [WinW:0]   sum_full;
  logic [WinW-1:0] sum_sat;
  logic [WinW-1:0] add;
  logic [WinW-1:0] grown;
  logic            ctr_not_pos;

  // Result register.
  logic [OutDataW-1:0] out_data_r;

  assign out_data = out_data_r;

  // Timeout with backoff halves the threshold instead of the flight size.
  always_comb begin
    if (in_req == REQ_TIMEOUT && in_data[FlightW+DupW+2]) begin
      dividend = thr_r[WinW-1:1];
    end else begin
      dividend = {1'b0, in_data[FlightW-1:1]};
    end
  end

  assign trial           = {rem_r, quo_r[DivW-1]};
  assign ge              = (trial >= {1'b0, mss_r});
  assign status.div_last = (cnt_r == '0);
  assign npkt            = (mss_r == '0) ? '0 : quo_r;

  assign mul_a_op = (npkt < DivW'(2)) ? WinW'(2) : {1'b0, npkt};
  assign mul_b_op = (req_r == REQ_DUPACK) ? ({1'b0, npkt} + WinW'(dup_r)) : {1'b0, npkt};
  assign mul_op   = cmd.mul_a ? mul_a_op : mul_b_op;
  assign prod     = mul_op * mss_r;
  assign prod_sat = (prod[WinW+MssW-1:WinW] != '0) ? SAT32 : prod[WinW-1:0];

  assign ctr_not_pos = (ctr_r == '0) || ctr_r[WinW-1];
  assign sum_full    = {1'b0, win_r} + {{(WinW-MssW+1){1'b0}}, mss_r};
  assign sum_sat     = sum_full[WinW] ? SAT32 : sum_full[WinW-1:0];

  always_comb begin
    win_nxt = win_r;
    thr_nxt = thr_r;
    ctr_nxt = ctr_r;
    fr_nxt  = fr_r;
    cr_nxt  = cr_r;
    add     = WinW'(mss_r);
    grown   = sum_sat;
    case (req_r)
      REQ_NEW_ACK: begin
        if (!fr_r && !cr_r) begin
          if (win_r >= thr_r) begin
            if (ctr_not_pos) begin
              ctr_nxt = sum_sat;
            end else begin
              ctr_nxt = ctr_r - WinW'(mss_r);
              add     = '0;
            end
          end
          grown   = (add == '0) ? win_r : sum_sat;
          win_nxt = (grown < limit_r) ? grown : limit_r;
        end
      end
      REQ_DUPACK: begin
        if (!fr_r) begin
          if (!cr_r) begin
            thr_nxt = thr_calc_r;
            win_nxt = win_calc_r;
          end
          fr_nxt = 1'b1;
          cr_nxt = 1'b1;
        end
      end
      REQ_ECN: begin
        if (!cr_r && !reduced_r) begin
          thr_nxt = thr_calc_r;
          win_nxt = win_calc_r;
          if (win_calc_r == '0) ctr_nxt = '0;
          cr_nxt = 1'b1;
        end
      end
      REQ_TIMEOUT: begin
        if (!reduced_r || rexmit_r) thr_nxt = thr_calc_r;
        win_nxt = WinW'(mss_r);
        ctr_nxt = '0;
      end
      REQ_EXIT: begin
        if (fr_r && (win_r > thr_r)) win_nxt = thr_r;
        ctr_nxt = '0;
        fr_nxt  = 1'b0;
        cr_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r   <= MSS_RESET;
      limit_r <= LIMIT_RESET;
      win_r   <= WIN_RESET;
      thr_r   <= SAT32;
      ctr_r   <= '0;
      fr_r    <= 1'b0;
      cr_r    <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MSS:   mss_r   <= cfg_wdata[MssW-1:0];
          CFG_LIMIT: limit_r <= cfg_wdata;
          default:   mss_r   <= mss_r;
        endcase
      end
      if (cmd.load) begin
        cnt_r <= DivCntW'(DivW - 1);
      end else if (cmd.div_step && cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.commit) begin
        win_r <= win_nxt;
        thr_r <= thr_nxt;
        ctr_r <= ctr_nxt;
        fr_r  <= fr_nxt;
        cr_r  <= cr_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req;
      dup_r     <= in_data[FlightW+DupW-1:FlightW];
      reduced_r <= in_data[FlightW+DupW];
      rexmit_r  <= in_data[FlightW+DupW+1];
      quo_r     <= dividend;
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DivW-2:0], ge};
      rem_r <= ge ? MssW'(trial - {1'b0, mss_r}) : trial[MssW-1:0];
    end
    if (cmd.mul_a) thr_calc_r <= prod_sat;
    if (cmd.mul_b) win_calc_r <= prod_sat;
    if (cmd.commit) begin
      out_data_r <= {6'd0, cr_nxt, fr_nxt, thr_nxt, win_nxt};
    end
  end

`ifndef SYNTHESIS
  a_fr_implies_cr: assert property (@(posedge clk) disable iff (!rst_n)
    fr_r |-> cr_r)
    else $error("fast recovery set without congestion recovery");
  a_rem_below_mss: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step && mss_r != '0) |=> (rem_r < mss_r))
    else $error("divider remainder not below MSS");
  a_exit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && req_r == REQ_EXIT) |=> (!fr_r && !cr_r && ctr_r == '0))
    else $error("recovery exit left state set");
`endif

endmodule

// ===== sim/tcp_reno_congestion_window_unit_tb.sv =====
// Self-checking bench for the TCP Reno congestion window unit: a directed table and
// random phases, with each result checked against a behavioral window model.
// Depends on tcrcw_pkg and tcp_reno_congestion_window_unit.
`timescale 1ns / 1ps

module tcp_reno_congestion_window_unit_tb
  import tcrcw_pkg::*;
;

  // One result as the unit reports it.
  typedef struct packed {
    logic [WinW-1:0] cwnd;
    logic [WinW-1:0] ssthresh;
    logic            fast_rec;
    logic            cong_rec;
  } cwnd_result_t;

  // Directed table: a request, or a register write made while the unit is idle.
  typedef enum logic [1:0] {ROW_REQ, ROW_SET_MSS, ROW_SET_LIMIT} row_kind_t;

  // sig_flags: [0] window_reduced, [1] is_retransmit, [2] backoff_active
  typedef struct packed {
    row_kind_t          kind;
    logic [ReqW-1:0]    req;
    logic [FlightW-1:0] flight;
    logic [DupW-1:0]    dupacks;
    logic [2:0]         sig_flags;
    logic [WinW-1:0]    cfg_value;
    logic               check;
    cwnd_result_t       want;
  } dir_row_t;

  localparam logic [FlightW-1:0] FLIGHT_MAX = 31'h7FFF_FFFF;
  localparam int NUM_ROWS = 29;

  // Rows with check set carry a hand-computed result; the rest use the model.
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // slow start growth right after reset, then no-op types
    '{ROW_REQ, REQ_NEW_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd5840, SAT32, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_OTHER_ACK, FLIGHT_MAX, 16'hFFFF, 3'b111, 32'd0, 1'b1,
      '{32'd5840, SAT32, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_EXIT, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd5840, SAT32, 1'b0, 1'b0}},
    // fast recovery: enter, ignore ACKs and a second dupack, exit to ssthresh
    '{ROW_REQ, REQ_DUPACK, 31'd29200, 16'd3, 3'b000, 32'd0, 1'b1,
      '{32'd18980, 32'd14600, 1'b1, 1'b1}},
    '{ROW_REQ, REQ_NEW_ACK, 31'd29200, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd18980, 32'd14600, 1'b1, 1'b1}},
    '{ROW_REQ, REQ_DUPACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd18980, 32'd14600, 1'b1, 1'b1}},
    '{ROW_REQ, REQ_EXIT, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd14600, 32'd14600, 1'b0, 1'b0}},
    // congestion avoidance: counter load grows, next ACK only counts down
    '{ROW_REQ, REQ_NEW_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd16060, 32'd14600, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_NEW_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b0, '0},
    // ECN with nothing in flight: zero window, floor of two segments
    '{ROW_REQ, REQ_ECN, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd2920, 1'b0, 1'b1}},
    '{ROW_REQ, REQ_ECN, 31'd29200, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd2920, 1'b0, 1'b1}},
    // dupack in congestion recovery only sets the flags
    '{ROW_REQ, REQ_DUPACK, 31'd29200, 16'd3, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd2920, 1'b1, 1'b1}},
    '{ROW_REQ, REQ_EXIT, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd2920, 1'b0, 1'b0}},
    // ECN after the window was already reduced is ignored
    '{ROW_REQ, REQ_ECN, 31'd29200, 16'd0, 3'b001, 32'd0, 1'b1,
      '{32'd0, 32'd2920, 1'b0, 1'b0}},
    // timeouts: threshold kept, backoff path, retransmit with full flight
    '{ROW_REQ, REQ_TIMEOUT, FLIGHT_MAX, 16'd0, 3'b101, 32'd0, 1'b1,
      '{32'd1460, 32'd2920, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_TIMEOUT, 31'd0, 16'd0, 3'b100, 32'd0, 1'b1,
      '{32'd1460, 32'd2920, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_TIMEOUT, FLIGHT_MAX, 16'd0, 3'b011, 32'd0, 1'b0, '0},
    // largest segment: dupack product saturates the window
    '{ROW_SET_MSS, REQ_OTHER_ACK, 31'd0, 16'd0, 3'b000, 32'd65535, 1'b0, '0},
    '{ROW_REQ, REQ_DUPACK, FLIGHT_MAX, 16'hFFFF, 3'b000, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_EXIT, 31'd0, 16'd0, 3'b000, 32'd0, 1'b0, '0},
    // zero cap pins ACK growth at zero
    '{ROW_SET_LIMIT, REQ_OTHER_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_NEW_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b0, '0},
    // zero segment size: every quotient and product is zero
    '{ROW_SET_MSS, REQ_OTHER_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b0, '0},
    '{ROW_REQ, REQ_ECN, FLIGHT_MAX, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b1}},
    '{ROW_REQ, REQ_TIMEOUT, FLIGHT_MAX, 16'd0, 3'b100, 32'd0, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b1}},
    '{ROW_REQ, REQ_EXIT, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    '{ROW_REQ, REQ_NEW_ACK, 31'd0, 16'd0, 3'b000, 32'd0, 1'b1,
      '{32'd0, 32'd0, 1'b0, 1'b0}},
    // open the cap fully and return to a common segment size
    '{ROW_SET_LIMIT, REQ_OTHER_ACK, 31'd0, 16'd0, 3'b000, SAT32, 1'b0, '0},
    '{ROW_SET_MSS, REQ_OTHER_ACK, 31'd0, 16'd0, 3'b000, 32'd1460, 1'b0, '0}
  };

  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [ReqW-1:0]     in_tuser = REQ_OTHER_ACK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = CFG_MSS;
  logic [WinW-1:0]     cfg_wdata = '0;

  // Model state: window, threshold, per-RTT byte counter, recovery flags, registers.
  logic [WinW-1:0] pred_cwnd;
  logic [WinW-1:0] pred_ssthresh;
  logic [WinW-1:0] pred_rtt_bytes;
  logic            pred_fast_rec;
  logic            pred_cong_rec;
  logic [MssW-1:0] pred_mss;
  logic [WinW-1:0] pred_cap;

  cwnd_result_t expected_windows[$];
  cwnd_result_t oldest;
  int           mismatches = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  int           stall_left = 0;

  tcp_reno_congestion_window_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tcp_reno_congestion_window_unit_tb: errors");
    $finish;
  end

  function automatic logic [WinW-1:0] clamp32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? SAT32 : v[WinW-1:0];
  endfunction

  // Whole segments in a byte count; a zero segment size yields zero.
  function automatic logic [WinW-1:0] segments(input logic [WinW-1:0] bytes);
    return (pred_mss == '0) ? '0 : bytes / {16'd0, pred_mss};
  endfunction

  // Threshold from a segment count, never below two segments.
  function automatic logic [WinW-1:0] floor_threshold(input logic [WinW-1:0] npkt);
    logic [WinW-1:0] n;
    n = (npkt < 32'd2) ? 32'd2 : npkt;
    return clamp32({32'd0, n} * {48'd0, pred_mss});
  endfunction

  // Apply one request to the model state and return the state the unit reports.
  task automatic reno_update(input logic [ReqW-1:0] req, input logic [FlightW-1:0] flight,
                             input logic [DupW-1:0] dupacks, input logic [2:0] sig_flags,
                             output cwnd_result_t res);
    logic [WinW-1:0] npkt;
    logic [WinW-1:0] step;
    logic [WinW-1:0] grown;
    npkt = segments({1'b0, flight} >> 1);
    case (req)
      REQ_NEW_ACK: begin
        if (!pred_fast_rec && !pred_cong_rec) begin
          step = {16'd0, pred_mss};
          if (pred_cwnd >= pred_ssthresh) begin
            // avoidance: reload the counter when spent, else count down and hold
            if (pred_rtt_bytes == '0 || pred_rtt_bytes[WinW-1]) begin
              pred_rtt_bytes = clamp32({32'd0, pred_cwnd} + {32'd0, step});
            end else begin
              pred_rtt_bytes = pred_rtt_bytes - step;
              step = '0;
            end
          end
          grown = clamp32({32'd0, pred_cwnd} + {32'd0, step});
          pred_cwnd = (grown < pred_cap) ? grown : pred_cap;
        end
      end
      REQ_DUPACK: begin
        if (!pred_fast_rec) begin
          if (!pred_cong_rec) begin
            pred_ssthresh = floor_threshold(npkt);
            pred_cwnd = clamp32(({32'd0, npkt} + {48'd0, dupacks}) * {48'd0, pred_mss});
          end
          pred_fast_rec = 1'b1;
          pred_cong_rec = 1'b1;
        end
      end
      REQ_ECN: begin
        if (!pred_cong_rec && !sig_flags[0]) begin
          pred_ssthresh = floor_threshold(npkt);
          pred_cwnd = clamp32({32'd0, npkt} * {48'd0, pred_mss});
          if (pred_cwnd == '0) begin
            pred_rtt_bytes = '0;
          end
          pred_cong_rec = 1'b1;
        end
      end
      REQ_TIMEOUT: begin
        if (!sig_flags[0] || sig_flags[1]) begin
          if (sig_flags[2]) begin
            npkt = segments(pred_ssthresh >> 1);
          end
          pred_ssthresh = floor_threshold(npkt);
        end
        pred_cwnd = {16'd0, pred_mss};
        pred_rtt_bytes = '0;
      end
      REQ_EXIT: begin
        if (pred_fast_rec && pred_cwnd > pred_ssthresh) begin
          pred_cwnd = pred_ssthresh;
        end
        pred_rtt_bytes = '0;
        pred_fast_rec = 1'b0;
        pred_cong_rec = 1'b0;
      end
      default: begin
      end
    endcase
    res = '{pred_cwnd, pred_ssthresh, pred_fast_rec, pred_cong_rec};
  endtask

  // Offer one request, hold it until accepted, then log what it should produce.
  // Valid stays high afterwards; the next request or settle_unit decides.
  task automatic send_request(input logic [ReqW-1:0] req, input logic [FlightW-1:0] flight,
                              input logic [DupW-1:0] dupacks, input logic [2:0] sig_flags,
                              input logic use_typed, input cwnd_result_t typed);
    cwnd_result_t predicted;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {6'd0, sig_flags, dupacks, flight};
    do @(posedge clk); while (!in_tready);
    reno_update(req, flight, dupacks, sig_flags, predicted);
    expected_windows.push_back(use_typed ? typed : predicted);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic settle_unit();
    in_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [WinW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_MSS) begin
      pred_mss = value[MssW-1:0];
    end else begin
      pred_cap = value;
    end
    @(posedge clk);
  endtask

  // Result side: hold tready low in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare every accepted result with the oldest outstanding expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_windows.size() == 0) begin
        $error("result with no request outstanding: %h", out_tdata);
        mismatches++;
      end else begin
        oldest = expected_windows.pop_front();
        if (out_tdata[31:0] !== oldest.cwnd) begin
          $error("congestion_window: expected %0d, actual %0d", oldest.cwnd, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[63:32] !== oldest.ssthresh) begin
          $error("slow_start_threshold: expected %0d, actual %0d",
                 oldest.ssthresh, out_tdata[63:32]);
          mismatches++;
        end
        if (out_tdata[64] !== oldest.fast_rec) begin
          $error("fast_recovery: expected %0b, actual %0b", oldest.fast_rec, out_tdata[64]);
          mismatches++;
        end
        if (out_tdata[65] !== oldest.cong_rec) begin
          $error("congestion_recovery: expected %0b, actual %0b",
                 oldest.cong_rec, out_tdata[65]);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t        row;
    int              phase;
    int              pick;
    logic [ReqW-1:0] req;
    logic [FlightW-1:0] flight;
    logic [DupW-1:0] dupacks;
    logic [2:0]      sig_flags;
    logic [MssW-1:0] mss_pick;
    logic [WinW-1:0] cap_pick;

    pred_cwnd      = WIN_RESET;
    pred_ssthresh  = SAT32;
    pred_rtt_bytes = '0;
    pred_fast_rec  = 1'b0;
    pred_cong_rec  = 1'b0;
    pred_mss       = MSS_RESET;
    pred_cap       = LIMIT_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table under moderate idling on both sides.
    gap_pct   = 30;
    stall_pct = 20;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_REQ: send_request(row.req, row.flight, row.dupacks, row.sig_flags,
                              row.check, row.want);
        ROW_SET_MSS: begin
          settle_unit();
          write_register(CFG_MSS, row.cfg_value);
        end
        default: begin
          settle_unit();
          write_register(CFG_LIMIT, row.cfg_value);
        end
      endcase
    end

    // Random part: each phase reprograms both registers on an idle unit.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      settle_unit();
      if (phase == 0) begin
        mss_pick = 16'd1;
        cap_pick = SAT32;
      end else begin
        case ($urandom_range(0, 4))
          0: mss_pick = 16'd1;
          1: mss_pick = 16'hFFFF;
          2: mss_pick = 16'd536;
          3: mss_pick = MSS_RESET;
          default: mss_pick = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 4))
          0: cap_pick = '0;
          1: cap_pick = SAT32;
          2: cap_pick = LIMIT_RESET;
          3: cap_pick = $urandom_range(0, 2_000_000);
          default: cap_pick = $urandom;
        endcase
      end
      write_register(CFG_MSS, {16'd0, mss_pick});
      write_register(CFG_LIMIT, cap_pick);

      // Idling varies by phase, including stretches with none; the last phase runs flat out.
      if (phase == NUM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick = $urandom_range(0, 2);
        gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
        pick = $urandom_range(0, 2);
        stall_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
      end

      repeat (PHASE_ITEMS) begin
        // ACK-heavy mix with frequent recovery entry and exit
        pick = $urandom_range(0, 99);
        if (pick < 45)      req = REQ_NEW_ACK;
        else if (pick < 50) req = REQ_OTHER_ACK;
        else if (pick < 62) req = REQ_DUPACK;
        else if (pick < 72) req = REQ_ECN;
        else if (pick < 80) req = REQ_TIMEOUT;
        else                req = REQ_EXIT;
        // flight mostly a few dozen segments, sometimes anything
        if ($urandom_range(0, 4) == 0) begin
          flight = 31'($urandom);
        end else begin
          flight = 31'($urandom_range(0, 64 * int'(pred_mss)));
        end
        if ($urandom_range(0, 9) < 7) begin
          dupacks = 16'($urandom_range(0, 8));
        end else begin
          dupacks = 16'($urandom);
        end
        sig_flags = 3'($urandom);
        send_request(req, flight, dupacks, sig_flags, 1'b0, '0);
      end
    end

    // Drain, then keep watching for stray results for TAIL_CYCLES.
    in_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tcp_reno_congestion_window_unit_tb: clean");
    end else begin
      $display("tcp_reno_congestion_window_unit_tb: errors");
    end
    $finish;
  end

endmodule

// ===== tcp_reno_congestion_window_unit.f =====
sv/tcrcw_pkg.sv
sv/tcrcw_ctrl.sv
sv/tcrcw_dp.sv
sv/tcp_reno_congestion_window_unit.sv
sim/tcp_reno_congestion_window_unit_tb.sv
